/* src/psr_pkg.sv */
// Shared types and constants for the polyphase sinc resampler.
package psr_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int COEF_W       = 18;
  localparam int PHASE_IN_W   = 7;
  localparam int TAP_W        = 5;
  localparam int RATIO_W      = 21;
  localparam int LEN_W        = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int MAX_OUT      = 16;
  localparam int MIN_STEP     = 4096;
  localparam int RATIO_RESET  = 65536;
  localparam int LEN_RESET    = 25;
  localparam int CENTER_RESET = 65536;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_COEF    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_COEF    = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATIO = 1'b0,
    REG_LEN   = 1'b1
  } reg_e;

  typedef struct packed {
    kind_e                      kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic [PHASE_IN_W-1:0]      phase;
    logic [TAP_W-1:0]           tap;
    logic signed [COEF_W-1:0]   value;
  } item_t;

endpackage

/* src/polyphase_sinc_resampler_unit.sv */
// Polyphase windowed-sinc sample-rate converter, top level.
// Input channel (in_valid_i / in_stall_o) takes one item: opcode 0 is an audio
// sample, 1 writes one coefficient, 2 restarts position and clears history.
// Output channel (out_valid_o / out_stall_i) gives resampled samples, with
// last_of_run_o set on the final result caused by one input sample.
// Configuration: cfg_we_i writes register cfg_idx_i (0 ratio step, 1 filter
// length) with cfg_data_i; write only while the block is idle.
// Items land in a two-entry queue; the execution side takes one at a time.
// Coefficient writes and restarts complete without leaving the idle state. A
// sample gives up to 16 results of L+1 taps each, computed by the single shared
// multiply-accumulate unit that reads one coefficient per cycle.
// Reset clears history, sets position to one sample and loads the default
// ratio and length; coefficients are undefined until written.
// If the receiver stalls, the finished result waits in the output register
// and the engine holds before its next result; the queue keeps accepting
// until full.
module polyphase_sinc_resampler_unit #(
  parameter int MAX_TAPS    = 32,
  parameter int HALF_PHASES = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [psr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [psr_pkg::RATIO_W-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          opcode_i,
  input  logic signed [psr_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [psr_pkg::PHASE_IN_W-1:0]      coef_phase_i,
  input  logic [psr_pkg::TAP_W-1:0]           coef_tap_i,
  input  logic signed [psr_pkg::COEF_W-1:0]   coef_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [psr_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                last_of_run_o
);

  localparam int NUM_ROWS = 2 * HALF_PHASES + 1;
  localparam int NUM_COLS = MAX_TAPS + 1;

  logic [psr_pkg::RATIO_W-1:0] ratio_q;
  logic [psr_pkg::LEN_W-1:0]   len_q;
  logic                        item_valid, item_take;
  psr_pkg::item_t              item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= psr_pkg::RATIO_W'(psr_pkg::RATIO_RESET);
      len_q   <= psr_pkg::LEN_W'(psr_pkg::LEN_RESET);
    end else if (cfg_we_i) begin
      unique case (psr_pkg::reg_e'(cfg_idx_i))
        psr_pkg::REG_RATIO: ratio_q <= cfg_data_i;
        psr_pkg::REG_LEN:   len_q   <= cfg_data_i[psr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  psr_front #(
    .NUM_ROWS(NUM_ROWS),
    .NUM_COLS(NUM_COLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .sample_in_i (sample_in_i),
    .coef_phase_i(coef_phase_i),
    .coef_tap_i  (coef_tap_i),
    .coef_value_i(coef_value_i),
    .item_valid_o(item_valid),
    .item_o      (item),
    .item_take_i (item_take)
  );

  psr_back #(
    .MAX_TAPS   (MAX_TAPS),
    .HALF_PHASES(HALF_PHASES),
    .NUM_ROWS   (NUM_ROWS),
    .NUM_COLS   (NUM_COLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .ratio_i      (ratio_q),
    .len_i        (len_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

/* src/psr_front.sv */
// Input side: accepts items, drops ones with no effect, and queues the rest.
module psr_front #(
  parameter int NUM_ROWS = 65,
  parameter int NUM_COLS = 33
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          opcode_i,
  input  logic signed [psr_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [psr_pkg::PHASE_IN_W-1:0]      coef_phase_i,
  input  logic [psr_pkg::TAP_W-1:0]           coef_tap_i,
  input  logic signed [psr_pkg::COEF_W-1:0]   coef_value_i,
  output logic                                item_valid_o,
  output psr_pkg::item_t                      item_o,
  input  logic                                item_take_i
);

  psr_pkg::item_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           keep;
  psr_pkg::kind_e kind;
  psr_pkg::item_t new_item;
  logic           push, pop;

  always_comb begin
    keep = 1'b0;
    kind = psr_pkg::KIND_SAMPLE;
    unique case (psr_pkg::opcode_e'(opcode_i))
      psr_pkg::OP_SAMPLE: begin
        keep = 1'b1;
        kind = psr_pkg::KIND_SAMPLE;
      end
      psr_pkg::OP_COEF: begin
        keep = (32'(coef_phase_i) < 32'(NUM_ROWS)) && (32'(coef_tap_i) < 32'(NUM_COLS));
        kind = psr_pkg::KIND_COEF;
      end
      psr_pkg::OP_RESTART: begin
        keep = 1'b1;
        kind = psr_pkg::KIND_RESTART;
      end
      default: keep = 1'b0;
    endcase
  end

  assign new_item.kind   = kind;
  assign new_item.sample = sample_in_i;
  assign new_item.phase  = coef_phase_i;
  assign new_item.tap    = coef_tap_i;
  assign new_item.value  = coef_value_i;

  assign in_stall_o   = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];
  assign push         = in_valid_i && !in_stall_o && keep;
  assign pop          = item_take_i && item_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= new_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

/* src/psr_back.sv */
// Execution side: history, coefficient memory, shared MAC and output register.
module psr_back #(
  parameter int MAX_TAPS    = 32,
  parameter int HALF_PHASES = 32,
  parameter int NUM_ROWS    = 65,
  parameter int NUM_COLS    = 33
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                item_valid_i,
  input  psr_pkg::item_t                      item_i,
  output logic                                item_take_o,
  input  logic [psr_pkg::RATIO_W-1:0]         ratio_i,
  input  logic [psr_pkg::LEN_W-1:0]           len_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [psr_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                last_of_run_o
);

  localparam int DEPTH   = NUM_ROWS * NUM_COLS;
  localparam int AW      = $clog2(DEPTH);
  localparam int HW      = $clog2(MAX_TAPS);
  localparam int PW      = $clog2(2 * HALF_PHASES + 1);
  localparam int LEN_MAX = MAX_TAPS - 1;
  localparam int C_W     = 34;
  localparam int POS_W   = 35;
  localparam int IPOS_W  = 19;
  localparam int PROD_W  = psr_pkg::SAMPLE_W + psr_pkg::COEF_W;
  localparam int ACC_W   = 48;
  localparam int N_W     = $clog2(psr_pkg::MAX_OUT + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SETUP  = 6'b000010,
    ST_ROW    = 6'b000100,
    ST_MAC    = 6'b001000,
    ST_ROUND  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e state_q;
  logic signed [psr_pkg::SAMPLE_W-1:0] hist_q [MAX_TAPS];
  logic signed [psr_pkg::COEF_W-1:0]   mem [DEPTH];
  logic signed [psr_pkg::COEF_W-1:0]   rdata_q;
  logic signed [psr_pkg::SAMPLE_W-1:0] samp_q;
  logic signed [PROD_W-1:0]            prod_q;
  logic signed [ACC_W-1:0]             acc_q;
  logic signed [31:0]                  center_q;
  logic signed [C_W-1:0]               c_q;
  logic signed [IPOS_W-1:0]            ipos_q;
  logic [PW-1:0]                       phase_q;
  logic [AW-1:0]                       row_base_q;
  logic [5:0]                          k_q;
  logic [N_W-1:0]                      n_q;
  logic                                v1_q, v2_q, pend_q;
  logic signed [psr_pkg::SAMPLE_W-1:0] res_q;
  logic                                out_valid_q, out_last_q;
  logic signed [psr_pkg::SAMPLE_W-1:0] out_data_q;

  logic [psr_pkg::LEN_W-1:0]  len_eff;
  logic [psr_pkg::RATIO_W-1:0] step;
  logic signed [POS_W-1:0]    pos;
  logic signed [IPOS_W-1:0]   ipos;
  logic signed [IPOS_W:0]     endpos;
  logic                       brk;
  logic [31:0]                ph_tmp, ph_full;
  logic [PW-1:0]              phase;
  logic [31:0]                rb_tmp, wa_tmp;
  logic signed [IPOS_W:0]     age;
  logic                       age_ok;
  logic                       issue;
  logic [AW-1:0]              raddr;
  logic                       mem_we;
  logic                       out_free;
  logic                       emit;
  logic signed [ACC_W-1:0]    rsum;
  logic signed [31:0]         r32;
  logic signed [psr_pkg::SAMPLE_W-1:0] r_sat;
  logic signed [31:0]         c_sat;
  logic signed [PROD_W-1:0]   prod;

  always_comb begin
    if (32'(len_i) > 32'(LEN_MAX)) len_eff = psr_pkg::LEN_W'(LEN_MAX);
    else len_eff = len_i;
    if (32'(ratio_i) < 32'(psr_pkg::MIN_STEP)) step = psr_pkg::RATIO_W'(psr_pkg::MIN_STEP);
    else step = ratio_i;
  end

  assign pos    = POS_W'(c_q) - $signed({{(POS_W - psr_pkg::LEN_W - 15){1'b0}}, len_eff, 15'b0});
  assign ipos   = pos[POS_W-1:16];
  assign endpos = {ipos[IPOS_W-1], ipos} + $signed({{(IPOS_W + 1 - psr_pkg::LEN_W){1'b0}}, len_eff});
  assign brk    = (endpos > 0) || (32'(n_q) == 32'(psr_pkg::MAX_OUT));

  always_comb begin
    ph_tmp  = {16'b0, pos[15:0]} * 32'(2 * HALF_PHASES) + 32'd32768;
    ph_full = {16'b0, ph_tmp[31:16]};
    if (ph_full > 32'(2 * HALF_PHASES)) phase = PW'(2 * HALF_PHASES);
    else phase = ph_full[PW-1:0];
    rb_tmp = 32'(phase_q) * 32'(NUM_COLS);
    wa_tmp = 32'(item_i.phase) * 32'(NUM_COLS) + 32'(item_i.tap);
  end

  assign issue  = (state_q == ST_MAC) && (k_q <= {1'b0, len_eff});
  assign age    = -({ipos_q[IPOS_W-1], ipos_q} + $signed({{(IPOS_W - 5){1'b0}}, k_q}));
  assign age_ok = !age[IPOS_W] && ({12'b0, age} < 32'(MAX_TAPS));
  assign raddr  = row_base_q + AW'(k_q);
  assign mem_we = (state_q == ST_IDLE) && item_valid_i && (item_i.kind == psr_pkg::KIND_COEF);
  assign prod   = rdata_q * samp_q;

  assign item_take_o = (state_q == ST_IDLE) && item_valid_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit        = (state_q == ST_SETUP) && pend_q && out_free;

  always_comb begin
    rsum = acc_q + ACC_W'(32768);
    r32  = rsum[ACC_W-1:16];
    if (r32 > 32'sd8388607) r_sat = 24'sh7fffff;
    else if (r32 < -32'sd8388608) r_sat = 24'sh800000;
    else r_sat = r32[psr_pkg::SAMPLE_W-1:0];
    if (!c_q[C_W-1] && (c_q[C_W-2:31] != 2'b00)) c_sat = 32'sh7fffffff;
    else if (c_q[C_W-1] && (c_q[C_W-2:31] != 2'b11)) c_sat = 32'sh80000000;
    else c_sat = c_q[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wa_tmp[AW-1:0]] <= item_i.value;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    samp_q <= age_ok ? hist_q[age[HW-1:0]] : '0;
    prod_q <= prod;
    if (state_q == ST_SETUP) begin
      ipos_q  <= ipos;
      phase_q <= phase;
    end
    if (state_q == ST_ROW) row_base_q <= rb_tmp[AW-1:0];
    if (state_q == ST_ROUND) res_q <= r_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int i = 0; i < MAX_TAPS; i++) hist_q[i] <= '0;
      center_q    <= 32'(psr_pkg::CENTER_RESET);
      c_q         <= '0;
      k_q         <= '0;
      n_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      pend_q      <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      v1_q <= issue;
      v2_q <= v1_q;
      if (v2_q) acc_q <= acc_q + ACC_W'(prod_q);
      if (issue) k_q <= k_q + 6'd1;
      unique case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            case (item_i.kind)
              psr_pkg::KIND_SAMPLE: begin
                hist_q[0] <= item_i.sample;
                for (int i = 1; i < MAX_TAPS; i++) hist_q[i] <= hist_q[i-1];
                c_q     <= C_W'(center_q) - C_W'(65536);
                n_q     <= '0;
                pend_q  <= 1'b0;
                state_q <= ST_SETUP;
              end
              psr_pkg::KIND_RESTART: begin
                for (int i = 0; i < MAX_TAPS; i++) hist_q[i] <= '0;
                center_q <= 32'(psr_pkg::CENTER_RESET);
              end
              default: ;
            endcase
          end
        end
        ST_SETUP: begin
          if (!pend_q || out_free) begin
            if (pend_q) begin
              out_data_q  <= res_q;
              out_last_q  <= brk;
              pend_q      <= 1'b0;
            end
            state_q <= brk ? ST_FINISH : ST_ROW;
          end
        end
        ST_ROW: begin
          k_q     <= '0;
          acc_q   <= '0;
          state_q <= ST_MAC;
        end
        ST_MAC: begin
          if (!issue && !v1_q && !v2_q) state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          pend_q  <= 1'b1;
          c_q     <= c_q + C_W'(step);
          n_q     <= n_q + N_W'(1);
          state_q <= ST_SETUP;
        end
        ST_FINISH: begin
          center_q <= c_sat;
          state_q  <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_data_q;
  assign last_of_run_o = out_last_q;

endmodule

/* tb/tb_polyphase_sinc_resampler_unit.sv */
// Self-checking testbench for the polyphase sinc resampler: random items, predicted results.
`timescale 1ns / 100ps

module tb_polyphase_sinc_resampler_unit;

  localparam int NTAPS   = 32;
  localparam int NROWS   = 65;
  localparam int NCOLS   = 33;
  localparam int WD_MAX  = 20000;
  localparam int HOLD_CY = 400;

  typedef struct {
    psr_pkg::opcode_e                    op;
    logic signed [psr_pkg::SAMPLE_W-1:0] smp;
    logic [psr_pkg::PHASE_IN_W-1:0]      row;
    logic [psr_pkg::TAP_W-1:0]           col;
    logic signed [psr_pkg::COEF_W-1:0]   val;
  } req_t;

  typedef struct {
    logic signed [psr_pkg::SAMPLE_W-1:0] smp;
    logic                                last;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [psr_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [psr_pkg::RATIO_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = '0;
  logic signed [psr_pkg::SAMPLE_W-1:0] sample_in = '0;
  logic [psr_pkg::PHASE_IN_W-1:0] coef_phase = '0;
  logic [psr_pkg::TAP_W-1:0] coef_tap = '0;
  logic signed [psr_pkg::COEF_W-1:0] coef_value = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [psr_pkg::SAMPLE_W-1:0] sample_out;
  logic last_of_run;

  req_t pending[$];
  res_t resampled[$];
  req_t cur;
  int   errors = 0;
  int   results_made = 0;
  int   send_idle = 38;
  int   recv_idle = 80;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_cnt = 0;
  int   quiet = 0;

  // predictor state
  longint hist[NTAPS];
  longint coefs[NROWS][NCOLS];
  longint center;
  int unsigned step_reg;
  int unsigned len_reg;

  polyphase_sinc_resampler_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .sample_in_i(sample_in), .coef_phase_i(coef_phase),
    .coef_tap_i(coef_tap), .coef_value_i(coef_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .sample_out_o(sample_out), .last_of_run_o(last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic resample(input req_t r);
    longint step, len, c, pos, ipos, frac, phase, acc, res, age;
    int n;
    res_t e;
    n = 0;
    case (r.op)
      psr_pkg::OP_COEF: begin
        if (r.row < NROWS && r.col < NCOLS) coefs[r.row][r.col] = r.val;
      end
      psr_pkg::OP_RESTART: begin
        foreach (hist[i]) hist[i] = 0;
        center = 65536;
      end
      psr_pkg::OP_SAMPLE: begin
        for (int i = NTAPS - 1; i > 0; i--) hist[i] = hist[i-1];
        hist[0] = r.smp;
        step = (step_reg < psr_pkg::MIN_STEP) ? psr_pkg::MIN_STEP : step_reg;
        len = (len_reg > NTAPS - 1) ? NTAPS - 1 : len_reg;
        c = center - 65536;
        while (n < psr_pkg::MAX_OUT) begin
          pos = c - len * 32768;
          ipos = pos >>> 16;
          if (ipos + len > 0) break;
          frac = pos - ipos * 65536;
          phase = (frac * 64 + 32768) / 65536;
          if (phase > 64) phase = 64;
          acc = 0;
          for (longint k = 0; k <= len; k++) begin
            age = -(ipos + k);
            if (age >= 0 && age < NTAPS) acc += hist[age] * coefs[phase][k];
          end
          res = (acc + 32768) >>> 16;
          if (res > 8388607) res = 8388607;
          if (res < -8388608) res = -8388608;
          e.smp = res[psr_pkg::SAMPLE_W-1:0];
          e.last = 1'b0;
          resampled.push_back(e);
          n++;
          c += step;
        end
        if (c > 64'sd2147483647) c = 64'sd2147483647;
        if (c < -64'sd2147483648) c = -64'sd2147483648;
        center = c;
        if (n > 0) resampled[$].last = 1'b1;
        results_made += n;
      end
      default: ;
    endcase
  endtask

  // sender
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) resample(cur);
      if (!in_valid || !in_stall) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur = pending.pop_front();
          in_valid <= 1'b1;
          opcode <= cur.op;
          sample_in <= cur.smp;
          coef_phase <= cur.row;
          coef_tap <= cur.col;
          coef_value <= cur.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    res_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (resampled.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected item: sample %0d last %0b", sample_out,
                                     last_of_run);
        end else begin
          e = resampled.pop_front();
          if (e.smp !== sample_out || e.last !== last_of_run) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: sample exp %0d got %0d, last exp %0b got %0b",
                       e.smp, sample_out, e.last, last_of_run);
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_cnt = HOLD_CY;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (pending.size() == 0 && !in_valid && resampled.size() == 0))
      quiet <= 0;
    else if (quiet >= WD_MAX) begin
      $display("FAILURE");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  function automatic req_t mk_sample(input logic signed [psr_pkg::SAMPLE_W-1:0] v);
    req_t r;
    r.op = psr_pkg::OP_SAMPLE;
    r.smp = v;
    r.row = psr_pkg::PHASE_IN_W'($urandom);
    r.col = psr_pkg::TAP_W'($urandom);
    r.val = psr_pkg::COEF_W'($urandom);
    return r;
  endfunction

  function automatic req_t mk_op(input psr_pkg::opcode_e op);
    req_t r;
    r = mk_sample(psr_pkg::SAMPLE_W'($urandom));
    r.op = op;
    return r;
  endfunction

  function automatic req_t mk_coef(input int row, input int col, input int val);
    req_t r;
    r = mk_op(psr_pkg::OP_COEF);
    r.row = psr_pkg::PHASE_IN_W'(row);
    r.col = psr_pkg::TAP_W'(col);
    r.val = psr_pkg::COEF_W'(val);
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 82) begin
      case ($urandom_range(7))
        0: r = mk_sample(24'sh7FFFFF);
        1: r = mk_sample(-24'sh800000);
        default: r = mk_sample(psr_pkg::SAMPLE_W'($urandom));
      endcase
    end else if (pick < 92) begin
      r = mk_coef(($urandom_range(9) == 0) ? int'($urandom_range(127, 65))
                                           : int'($urandom_range(64)),
                  int'($urandom_range(31)), int'($urandom));
    end else if (pick < 97) begin
      r = mk_op(psr_pkg::OP_RESTART);
    end else begin
      r = mk_op(psr_pkg::OP_NONE);
    end
    return r;
  endfunction

  task automatic wait_idle();
    while (pending.size() > 0 || in_valid || resampled.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input psr_pkg::reg_e idx, input logic [psr_pkg::RATIO_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == psr_pkg::REG_RATIO) step_reg = 32'(data);
    else len_reg = 32'(data[psr_pkg::LEN_W-1:0]);
  endtask

  task automatic run_phase(input int n_items, input int min_results);
    int sent, base;
    sent = 0;
    base = results_made;
    while (sent < n_items || results_made - base < min_results) begin
      repeat (25) pending.push_back(rand_req());
      sent += 25;
      while (pending.size() > 0) @(posedge clk);
    end
  endtask

  initial begin
    foreach (hist[i]) hist[i] = 0;
    center = 65536;
    step_reg = psr_pkg::RATIO_RESET;
    len_reg = psr_pkg::LEN_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // default setting: unit step and odd length keep every window on the middle row
    for (int t = 0; t < NCOLS; t++) pending.push_back(mk_coef(32, t, 131071));
    repeat (14) pending.push_back(mk_sample(24'sh7FFFFF));
    repeat (4) pending.push_back(mk_sample(-24'sh800000));
    pending.push_back(mk_coef(32, 0, -131072));
    pending.push_back(mk_coef(100, 3, 5));
    pending.push_back(mk_op(psr_pkg::OP_NONE));
    pending.push_back(mk_op(psr_pkg::OP_RESTART));
    wait_idle();
    for (int t = 0; t < NCOLS; t++) pending.push_back(mk_coef(32, t, int'($urandom)));
    run_phase(50, 10);
    wait_idle();

    // half-sample step with odd length: windows land on the first and middle rows
    for (int t = 0; t < NCOLS; t++) pending.push_back(mk_coef(0, t, int'($urandom)));
    wait_idle();
    write_reg(psr_pkg::REG_RATIO, 21'd32768);
    write_reg(psr_pkg::REG_LEN, 21'd31);
    pending.push_back(mk_op(psr_pkg::OP_RESTART));
    repeat (20) pending.push_back(rand_req());
    hold_req++;
    run_phase(50, 10);
    wait_idle();

    send_idle = 80;
    recv_idle = 38;
    write_reg(psr_pkg::REG_RATIO, 21'd1048576);
    write_reg(psr_pkg::REG_LEN, 21'h1FFFE1);
    pending.push_back(mk_op(psr_pkg::OP_RESTART));
    run_phase(25, 2);
    wait_idle();

    // single-tap filters from here on: tap 0 of every row
    for (int p = 0; p < NROWS; p++) pending.push_back(mk_coef(p, 0, int'($urandom)));
    wait_idle();
    write_reg(psr_pkg::REG_RATIO, 21'd100);
    write_reg(psr_pkg::REG_LEN, 21'd0);
    pending.push_back(mk_op(psr_pkg::OP_RESTART));
    run_phase(25, 20);
    wait_idle();

    send_idle = 0;
    recv_idle = 0;
    write_reg(psr_pkg::REG_RATIO, 21'h1FFFFF);
    pending.push_back(mk_op(psr_pkg::OP_RESTART));
    run_phase(25, 1);
    wait_idle();

    write_reg(psr_pkg::REG_RATIO, psr_pkg::RATIO_W'($urandom_range(200000)));
    pending.push_back(mk_op(psr_pkg::OP_RESTART));
    run_phase(25, 1);
    wait_idle();

    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
